[src/awvn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package awvn_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int IDX_BITS = 10;
    localparam int COORD_BITS = 24;
    localparam int NORMAL_BITS = 16;
    localparam int SUM_BITS = 64;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS + 1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [IDX_BITS-1:0] first_index;
        logic [IDX_BITS-1:0] second_index;
        logic [IDX_BITS-1:0] third_index;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } t_req;

    typedef struct packed {
        logic signed [NORMAL_BITS-1:0] normal_x;
        logic signed [NORMAL_BITS-1:0] normal_y;
        logic signed [NORMAL_BITS-1:0] normal_z;
        logic is_degenerate;
    } t_rsp;

    typedef struct packed {
        logic start;
        logic [SUM_BITS-1:0] sx;
        logic [SUM_BITS-1:0] sy;
        logic [SUM_BITS-1:0] sz;
    } t_norm_cmd;
endpackage
`default_nettype wire

[src/awvn_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
module awvn_norm (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  awvn_pkg::t_norm_cmd     i_cmd,
    output logic                    o_busy,
    output awvn_pkg::t_rsp          o_rsp
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_SQ = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam int NB = awvn_pkg::NORMAL_BITS;
    localparam logic [4:0] DIV_LAST = 5'(NB - 1);

    logic [2:0] r_st;
    logic [63:0] r_a [3];
    logic [2:0] r_neg;
    logic [63:0] r_q, r_rem, r_root, r_bit, r_dsh;
    logic [1:0] r_k;
    logic [4:0] r_cnt;
    logic [NB-2:0] r_quo;
    logic [NB-1:0] r_res [3];
    logic r_deg;

    logic [63:0] m, mx;
    logic [31:0] w_sq_in;
    logic [63:0] prod;
    logic [64:0] trial;
    logic w_dge;
    logic [NB-2:0] w_quo_nx;
    logic [NB-1:0] w_signed;

    always_comb begin
        mx = (r_a[0] > r_a[1]) ? r_a[0] : r_a[1];
        m = (mx > r_a[2]) ? mx : r_a[2];
        w_sq_in = r_a[r_k][31:0];
        prod = {32'd0, w_sq_in} * {32'd0, w_sq_in};
        trial = {1'b0, r_rem} - {1'b0, r_root + r_bit};
        w_dge = (r_rem >= r_dsh);
        w_quo_nx = {r_quo[NB-3:0], w_dge};
        w_signed = r_neg[r_k] ? -{1'b0, w_quo_nx} : {1'b0, w_quo_nx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_a[0] <= i_cmd.sx[63] ? -i_cmd.sx : i_cmd.sx;
                        r_a[1] <= i_cmd.sy[63] ? -i_cmd.sy : i_cmd.sy;
                        r_a[2] <= i_cmd.sz[63] ? -i_cmd.sz : i_cmd.sz;
                        r_neg <= {i_cmd.sz[63], i_cmd.sy[63], i_cmd.sx[63]};
                        r_st <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (m == 64'd0) begin
                        r_deg <= 1'b1;
                        r_res[0] <= '0;
                        r_res[1] <= '0;
                        r_res[2] <= '0;
                        r_st <= S_DONE;
                    end else if (m >= 64'h8000_0000) begin
                        r_a[0] <= r_a[0] >> 1;
                        r_a[1] <= r_a[1] >> 1;
                        r_a[2] <= r_a[2] >> 1;
                    end else if (m < 64'h4000_0000) begin
                        r_a[0] <= r_a[0] << 1;
                        r_a[1] <= r_a[1] << 1;
                        r_a[2] <= r_a[2] << 1;
                    end else begin
                        r_deg <= 1'b0;
                        r_q <= '0;
                        r_k <= 2'd0;
                        r_st <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_q <= r_q + prod;
                    if (r_k == 2'd2) begin
                        r_rem <= r_q + prod;
                        r_root <= '0;
                        r_bit <= 64'h4000_0000_0000_0000;
                        r_st <= S_SQRT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_SQRT: begin
                    if (!trial[64]) begin
                        r_rem <= trial[63:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_k <= 2'd0;
                        r_cnt <= '0;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 5'd0) begin
                        r_rem <= (r_a[r_k] << (NB - 1)) + r_root;
                        r_dsh <= r_root << (NB - 1);
                        r_quo <= '0;
                        r_cnt <= 5'd1;
                    end else begin
                        if (w_dge) begin
                            r_rem <= r_rem - r_dsh;
                        end
                        r_dsh <= r_dsh >> 1;
                        r_quo <= w_quo_nx;
                        if (r_cnt == DIV_LAST) begin
                            r_res[r_k] <= w_signed;
                            r_cnt <= 5'd0;
                            if (r_k == 2'd2) begin
                                r_st <= S_DONE;
                            end else begin
                                r_k <= r_k + 2'd1;
                            end
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                S_DONE: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_rsp = '{normal_x: r_res[0], normal_y: r_res[1], normal_z: r_res[2],
                     is_degenerate: r_deg};
endmodule
`default_nettype wire

[src/area_weighted_vertex_normals.sv]
`timescale 1ns / 1ps
`default_nettype none
// Area-weighted vertex normals.
// Request channel: i_req_valid / o_req_stall carry one t_req per request.
// One request is worked at a time; o_req_stall is high while busy and a new
// request is taken in the first idle cycle.
//   Load (0) writes a position and clears that vertex's sum.
//   Triangle (1) reads three positions, forms the cross product and does
//   one sum read-modify-write per corner.
//   Read (2) reads one sum and normalizes it in a shared iterative unit:
//   a shift search, a 32-step square root and three restoring divides;
//   a zero sum skips the root and divides and responds as degenerate.
// Response channel: o_rsp_valid / i_rsp_stall; only reads respond.
// A stalled response holds in the output register; a following read still
// normalizes, then waits with the input stalled until the register frees.
// Reset clears control state only; memory contents are undefined until a
// vertex is loaded.
module area_weighted_vertex_normals (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    output logic                 o_req_stall,
    input  awvn_pkg::t_req       i_req,
    output logic                 o_rsp_valid,
    input  wire                  i_rsp_stall,
    output awvn_pkg::t_rsp       o_rsp
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD = 4'd1;
    localparam logic [3:0] S_CAP = 4'd2;
    localparam logic [3:0] S_CROSS = 4'd3;
    localparam logic [3:0] S_ACC_RD = 4'd4;
    localparam logic [3:0] S_ACC_WR = 4'd5;
    localparam logic [3:0] S_NRD = 4'd6;
    localparam logic [3:0] S_NWAIT = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;
    localparam logic [3:0] S_MUL = 4'd9;
    localparam int CB = awvn_pkg::COORD_BITS;
    localparam int DB = awvn_pkg::DIFF_BITS;
    localparam int PB = awvn_pkg::PROD_BITS;
    localparam int IB = awvn_pkg::IDX_BITS;

    logic [3:0] r_st;
    awvn_pkg::t_req r_req;
    logic [1:0] r_k;

    logic [3*CB-1:0] r_pos_mem [awvn_pkg::MAX_VERTICES];
    logic [3*64-1:0] r_sum_mem [awvn_pkg::MAX_VERTICES];
    logic [3*CB-1:0] r_pos_q;
    logic [3*64-1:0] r_sum_q;
    logic [IB-1:0] w_addr;
    logic w_pos_we, w_sum_we;
    logic [3*CB-1:0] w_pos_wd;
    logic [3*64-1:0] w_sum_wd;

    logic signed [CB-1:0] r_p [3][3];
    logic signed [DB-1:0] w_a [3], w_b [3];
    logic signed [PB-1:0] r_m [6];
    logic signed [63:0] r_n [3];

    awvn_pkg::t_norm_cmd w_cmd;
    logic w_nbusy;
    awvn_pkg::t_rsp w_nrsp;

    logic w_rsp_load;
    awvn_pkg::t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            r_pos_mem[w_addr] <= w_pos_wd;
        end
        r_pos_q <= r_pos_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_sum_we) begin
            r_sum_mem[w_addr] <= w_sum_wd;
        end
        r_sum_q <= r_sum_mem[w_addr];
    end

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        begin
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63]) begin
                s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            end
            return s;
        end
    endfunction

    always_comb begin
        case (r_k)
            2'd0: w_addr = r_req.first_index;
            2'd1: w_addr = r_req.second_index;
            default: w_addr = r_req.third_index;
        endcase
        w_pos_we = (r_st == S_RD) && (r_req.operation == awvn_pkg::OP_LOAD);
        w_pos_wd = {r_req.pos_z, r_req.pos_y, r_req.pos_x};
        w_sum_we = w_pos_we || (r_st == S_ACC_WR);
        if (r_st == S_ACC_WR) begin
            w_sum_wd = {sat_add(r_sum_q[191:128], r_n[2]),
                        sat_add(r_sum_q[127:64], r_n[1]),
                        sat_add(r_sum_q[63:0], r_n[0])};
        end else begin
            w_sum_wd = '0;
        end
        for (int i = 0; i < 3; i++) begin
            w_a[i] = DB'(r_p[1][i]) - DB'(r_p[0][i]);
            w_b[i] = DB'(r_p[2][i]) - DB'(r_p[0][i]);
        end
        w_cmd.start = (r_st == S_NWAIT);
        w_cmd.sx = r_sum_q[63:0];
        w_cmd.sy = r_sum_q[127:64];
        w_cmd.sz = r_sum_q[191:128];
        w_rsp_load = (r_st == S_OUT) && !w_nbusy && (!o_rsp_valid || !i_rsp_stall);
    end

    awvn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_busy  (w_nbusy),
        .o_rsp   (w_nrsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_rsp_valid <= 1'b0;
            r_k <= 2'd0;
        end else begin
            if (w_rsp_load) begin
                r_rsp <= w_nrsp;
                o_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                o_rsp_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    r_k <= 2'd0;
                    if (i_req_valid) begin
                        r_req <= i_req;
                        case (i_req.operation)
                            awvn_pkg::OP_LOAD: r_st <= S_RD;
                            awvn_pkg::OP_TRI: r_st <= S_RD;
                            awvn_pkg::OP_READ: r_st <= S_NRD;
                            default: r_st <= S_IDLE;
                        endcase
                    end
                end
                S_RD: begin
                    if (r_req.operation == awvn_pkg::OP_LOAD) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_st <= S_CAP;
                    end
                end
                S_CAP: begin
                    r_p[r_k][0] <= r_pos_q[CB-1:0];
                    r_p[r_k][1] <= r_pos_q[2*CB-1:CB];
                    r_p[r_k][2] <= r_pos_q[3*CB-1:2*CB];
                    if (r_k == 2'd2) begin
                        r_st <= S_MUL;
                    end else begin
                        r_k <= r_k + 2'd1;
                        r_st <= S_RD;
                    end
                end
                S_MUL: begin
                    r_m[0] <= PB'(w_a[1]) * PB'(w_b[2]);
                    r_m[1] <= PB'(w_a[2]) * PB'(w_b[1]);
                    r_m[2] <= PB'(w_a[2]) * PB'(w_b[0]);
                    r_m[3] <= PB'(w_a[0]) * PB'(w_b[2]);
                    r_m[4] <= PB'(w_a[0]) * PB'(w_b[1]);
                    r_m[5] <= PB'(w_a[1]) * PB'(w_b[0]);
                    r_st <= S_CROSS;
                end
                S_CROSS: begin
                    r_n[0] <= 64'(r_m[0]) - 64'(r_m[1]);
                    r_n[1] <= 64'(r_m[2]) - 64'(r_m[3]);
                    r_n[2] <= 64'(r_m[4]) - 64'(r_m[5]);
                    r_k <= 2'd0;
                    r_st <= S_ACC_RD;
                end
                S_ACC_RD: r_st <= S_ACC_WR;
                S_ACC_WR: begin
                    if (r_k == 2'd2) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_k <= r_k + 2'd1;
                        r_st <= S_ACC_RD;
                    end
                end
                S_NRD: r_st <= S_NWAIT;
                S_NWAIT: begin
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (w_rsp_load) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_req_stall = (r_st != S_IDLE);
    assign o_rsp = r_rsp;

    a_norm_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> !w_nbusy)
        else $error("normalizer state");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pos_we |-> w_sum_we) else $error("load must clear sum");
    a_rsp_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_st == S_OUT)) else $error("stray response");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response changed");
endmodule
`default_nettype wire

[test/tb_area_weighted_vertex_normals.sv]
`timescale 1ns / 1ps
module tb_area_weighted_vertex_normals;
    localparam int VERTS = 1024;
    localparam int RANDOM_REQUESTS = 2000;
    localparam int DRAIN_AT = 300;
    localparam int HOLDOFF_AT = 900;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int QUIET_FROM = 20000;
    localparam int QUIET_TO = 45000;
    localparam int NB = awvn_pkg::NORMAL_BITS;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic signed [awvn_pkg::COORD_BITS-1:0] CMAX = 24'sh7fffff;
    localparam logic signed [awvn_pkg::COORD_BITS-1:0] CMIN = -24'sh800000;
    localparam longint SUM_MAX = 64'sh7fffffffffffffff;
    localparam longint SUM_MIN = -64'sh7fffffffffffffff - 64'sd1;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    awvn_pkg::t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall;
    awvn_pkg::t_rsp o_rsp;

    area_weighted_vertex_normals u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req(i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp(o_rsp)
    );

    awvn_pkg::t_req pending_q[$];
    awvn_pkg::t_rsp normal_q[$];
    longint pos_x[VERTS];
    longint pos_y[VERTS];
    longint pos_z[VERTS];
    longint sum_x[VERTS];
    longint sum_y[VERTS];
    longint sum_z[VERTS];
    bit gen_loaded[VERTS];
    int loaded_list[$];
    int accepted;
    int cycles;
    int mismatches;
    int holdoff_left;
    bit holdoff_done;
    bit req_taken;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint sat_add(longint a, longint b);
        longint r;
        r = a + b;
        if (a >= 0 && b >= 0 && r < 0) return SUM_MAX;
        if (a < 0 && b < 0 && r >= 0) return SUM_MIN;
        return r;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic awvn_pkg::t_rsp unit_normal(longint s0, longint s1, longint s2);
        longint s[3];
        longint unsigned a[3];
        longint unsigned m;
        longint unsigned q;
        longint unsigned len;
        longint unsigned r;
        longint v[3];
        int rs;
        int ls;
        awvn_pkg::t_rsp res;
        s[0] = s0;
        s[1] = s1;
        s[2] = s2;
        m = 0;
        rs = 0;
        ls = 0;
        q = 0;
        for (int k = 0; k < 3; k++) begin
            a[k] = s[k] < 0 ? 64'd0 - longint'(s[k]) : s[k];
            if (a[k] > m) m = a[k];
        end
        res = '0;
        if (m == 0) begin
            res.is_degenerate = 1'b1;
            return res;
        end
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            rs++;
        end
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            ls++;
        end
        for (int k = 0; k < 3; k++) begin
            a[k] = (a[k] >> rs) << ls;
            q = q + a[k] * a[k];
        end
        len = root64(q);
        for (int k = 0; k < 3; k++) begin
            r = (2 * (64'd1 << (NB - 2)) * a[k] + len) / (2 * len);
            v[k] = s[k] < 0 ? -longint'(r) : longint'(r);
        end
        res.normal_x = v[0][NB-1:0];
        res.normal_y = v[1][NB-1:0];
        res.normal_z = v[2][NB-1:0];
        return res;
    endfunction

    task automatic apply_request(awvn_pkg::t_req r);
        longint ax, ay, az, bx, by, bz, nx, ny, nz;
        int c[3];
        c[0] = r.first_index;
        c[1] = r.second_index;
        c[2] = r.third_index;
        case (r.operation)
            awvn_pkg::OP_LOAD: begin
                pos_x[c[0]] = r.pos_x;
                pos_y[c[0]] = r.pos_y;
                pos_z[c[0]] = r.pos_z;
                sum_x[c[0]] = 0;
                sum_y[c[0]] = 0;
                sum_z[c[0]] = 0;
            end
            awvn_pkg::OP_TRI: begin
                ax = pos_x[c[1]] - pos_x[c[0]];
                ay = pos_y[c[1]] - pos_y[c[0]];
                az = pos_z[c[1]] - pos_z[c[0]];
                bx = pos_x[c[2]] - pos_x[c[0]];
                by = pos_y[c[2]] - pos_y[c[0]];
                bz = pos_z[c[2]] - pos_z[c[0]];
                nx = ay * bz - az * by;
                ny = az * bx - ax * bz;
                nz = ax * by - ay * bx;
                for (int k = 0; k < 3; k++) begin
                    sum_x[c[k]] = sat_add(sum_x[c[k]], nx);
                    sum_y[c[k]] = sat_add(sum_y[c[k]], ny);
                    sum_z[c[k]] = sat_add(sum_z[c[k]], nz);
                end
            end
            awvn_pkg::OP_READ:
                normal_q.push_back(unit_normal(sum_x[c[0]], sum_y[c[0]], sum_z[c[0]]));
            default: ;
        endcase
    endtask

    task automatic queue_request(logic [1:0] op, int a, int b, int c,
                                 logic [23:0] x, logic [23:0] y, logic [23:0] z);
        awvn_pkg::t_req r;
        r.operation = op;
        r.first_index = a;
        r.second_index = b;
        r.third_index = c;
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        if (op == awvn_pkg::OP_LOAD && !gen_loaded[a]) begin
            gen_loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
        pending_q.push_back(r);
    endtask

    function automatic logic [23:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom_range(0, 1) ? CMAX : CMIN;
        if (sel < 5) return 24'($signed($urandom_range(0, 2000)) - 1000);
        return $urandom;
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycles <= 0;
            req_taken <= 1'b0;
        end else begin
            cycles <= cycles + 1;
            req_taken <= i_req_valid && !o_req_stall;
            if (i_req_valid && !o_req_stall) begin
                apply_request(i_req);
                void'(pending_q.pop_front());
                accepted <= accepted + 1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (i_req_valid && !req_taken) begin
            i_req_valid <= 1'b1;
        end else if (pending_q.size() != 0
                     && !(accepted == DRAIN_AT && normal_q.size() != 0)
                     && ((cycles >= QUIET_FROM && cycles < QUIET_TO)
                         || $urandom_range(0, 99) >= 17)) begin
            i_req_valid <= 1'b1;
            i_req <= pending_q[0];
        end else begin
            i_req_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end else if (!holdoff_done && accepted >= HOLDOFF_AT) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            i_rsp_stall <= 1'b1;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            i_rsp_stall <= 1'b1;
        end else if (cycles >= QUIET_FROM && cycles < QUIET_TO) begin
            i_rsp_stall <= 1'b0;
        end else begin
            i_rsp_stall <= $urandom_range(0, 99) < 17;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (normal_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal %h", o_rsp);
            end else begin
                if (o_rsp.normal_x !== normal_q[0].normal_x
                    || o_rsp.normal_y !== normal_q[0].normal_y
                    || o_rsp.normal_z !== normal_q[0].normal_z
                    || o_rsp.is_degenerate !== normal_q[0].is_degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"normal mismatch: expected %0d %0d %0d deg %0b,",
                                  " got %0d %0d %0d deg %0b"},
                                 normal_q[0].normal_x, normal_q[0].normal_y,
                                 normal_q[0].normal_z, normal_q[0].is_degenerate,
                                 o_rsp.normal_x, o_rsp.normal_y, o_rsp.normal_z,
                                 o_rsp.is_degenerate);
                end
                void'(normal_q.pop_front());
            end
        end
    end

    initial begin
        #(20ms);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int sel;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_rsp_stall = 1'b0;
        i_req = '0;
        accepted = 0;
        cycles = 0;
        mismatches = 0;

        queue_request(awvn_pkg::OP_LOAD, 0, 0, 0, 24'd0, 24'd0, CMIN);
        queue_request(awvn_pkg::OP_LOAD, 1023, 0, 0, CMAX, CMIN, 24'd0);
        queue_request(awvn_pkg::OP_LOAD, 512, 0, 0, CMIN, CMAX, CMAX);
        queue_request(awvn_pkg::OP_TRI, 0, 1023, 512, 0, 0, 0);
        queue_request(awvn_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_READ, 1023, 0, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_READ, 512, 0, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_LOAD, 1, 0, 0, 24'd1, 24'd0, 24'd0);
        queue_request(awvn_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_TRI, 1, 1, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
        queue_request(OP_NONE, 1023, 1023, 1023, '1, '1, '1);
        queue_request(awvn_pkg::OP_LOAD, 2, 0, 0, 24'd0, 24'd1, 24'd0);
        queue_request(awvn_pkg::OP_LOAD, 3, 0, 0, 24'd0, 24'd0, 24'd1);
        queue_request(awvn_pkg::OP_TRI, 1, 2, 3, 0, 0, 0);
        queue_request(awvn_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_READ, 2, 0, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_READ, 3, 0, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_TRI, 3, 2, 1, 0, 0, 0);
        queue_request(awvn_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
        queue_request(awvn_pkg::OP_LOAD, 0, 0, 0, 24'd0, 24'd0, CMIN);
        queue_request(awvn_pkg::OP_READ, 0, 0, 0, 0, 0, 0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 22 || loaded_list.size() < 4) begin
                queue_request(awvn_pkg::OP_LOAD, $urandom_range(0, VERTS - 1), 0, 0,
                              rand_coord(), rand_coord(), rand_coord());
            end else if (sel < 70) begin
                if ($urandom_range(0, 9) == 0)
                    queue_request(awvn_pkg::OP_TRI, pick_loaded(), pick_loaded(),
                                  loaded_list[0], 0, 0, 0);
                else
                    queue_request(awvn_pkg::OP_TRI, pick_loaded(), pick_loaded(),
                                  pick_loaded(), $urandom, $urandom, $urandom);
            end else if (sel < 96) begin
                queue_request(awvn_pkg::OP_READ, pick_loaded(), $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            end else begin
                queue_request(OP_NONE, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_q.size() == 0 && normal_q.size() == 0);
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && normal_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
